// ===== rtl/mbfc04_pkg.sv =====
`default_nettype none
package mbfc04_pkg;

  localparam int RX_BUFFER_BYTES = 256;
  localparam int TABLE_ENTRIES   = 16;
  localparam int LEN_W           = 9;
  localparam int TBL_AW          = 4;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_GAP   = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_REG_BASE   = 2'd1;
  localparam logic [1:0] CFG_STUCK_MS   = 2'd2;

  localparam logic [7:0] FC_READ_INPUT = 8'h04;
  localparam logic [7:0] EXC_FLAG      = 8'h80;
  localparam logic [7:0] REPLY_COUNT   = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_DATA = 8'h03;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Modbus CRC-16, one byte, reflected
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/modbus_rtu_fc04_slave_core.sv =====
`default_nettype none
// Modbus RTU slave core for Read Input Registers (function 04, one register).
// Each input transaction (received byte, frame gap, millisecond tick or table
// write) is one input beat; the CRC of the incoming frame is kept running
// byte by byte, so a gap decides the frame at once. A valid request starts a
// 7-byte reply or a 5-byte exception, one byte per cycle while the sink is
// ready. Accepting the gap starts the sequencer and reads the table entry from
// the synchronous memory; the first byte is then loaded into the output
// register once that register is free. Bytes, ticks and table writes keep being
// accepted while a response goes out; a further gap waits until the last byte of
// the current response has been loaded into the output register. Nothing is
// accepted during reset.
// Counter fields carry the totals as they stood when the frame was decided.
module modbus_rtu_fc04_slave_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // data_byte[7:0], reg_index[11:8], reg_value[27:12]
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // tx_byte[7:0], crc_fail_count[23:8],
                                      // exception_count[39:24], stuck_count[55:40]
  output logic             m_tlast,   // last_byte
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef logic [mbfc04_pkg::LEN_W-1:0] len_t;

  localparam len_t RX_MAX = len_t'(mbfc04_pkg::RX_BUFFER_BYTES);

  logic [7:0]  slave_address;
  logic [15:0] register_base;
  logic [15:0] stuck_timeout_ms;

  logic [mbfc04_pkg::LEN_W-1:0] frame_length;
  logic [15:0] idle_ms;
  logic [15:0] crc_rx;
  logic [7:0]  hdr [6];
  logic [15:0] crc_fail_total;
  logic [15:0] exception_total;
  logic [15:0] stuck_total;

  logic [15:0] tbl_mem [mbfc04_pkg::TABLE_ENTRIES];
  logic [mbfc04_pkg::TABLE_ENTRIES-1:0] tbl_valid;
  logic [15:0] rd_data;
  logic        rd_valid;

  logic        busy;
  logic        tx_exc;
  logic [2:0]  tx_idx;
  logic [7:0]  tx_b1;
  logic [7:0]  tx_b2;
  logic [15:0] crc_tx;
  logic [15:0] snap_crc;
  logic [15:0] snap_exc;
  logic [15:0] snap_stuck;

  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;
  logic        accept;

  logic [15:0] crc_rx_next;
  logic [15:0] idle_ms_next;
  logic [15:0] start_addr;
  logic [15:0] qty;
  logic [15:0] offset;
  logic        frame_ok;
  logic        crc_bad;
  logic        exc_func;
  logic        exc_data;
  logic        exc_addr;
  logic        start_rsp;
  logic [7:0]  exc_code;

  logic [2:0]  body_n;
  logic [2:0]  last_idx;
  logic [15:0] tbl_val;
  logic [7:0]  cur_byte;
  logic        load;

  assign func      = s_tuser;
  assign data_byte = s_tdata[7:0];
  assign reg_index = s_tdata[11:8];
  assign reg_value = s_tdata[27:12];

  assign s_tready = !rst && (!busy || (func != mbfc04_pkg::FUNC_GAP));
  assign accept   = s_tvalid && s_tready;

  assign crc_rx_next  = mbfc04_pkg::crc16_byte(
                          (frame_length == '0) ? mbfc04_pkg::CRC_INIT : crc_rx, data_byte);
  assign idle_ms_next = (idle_ms == 16'hFFFF) ? idle_ms : idle_ms + 16'd1;

  assign start_addr = {hdr[2], hdr[3]};
  assign qty        = {hdr[4], hdr[5]};
  assign offset     = start_addr - register_base;

  always_comb begin
    frame_ok = (frame_length >= len_t'(4)) && (hdr[0] == slave_address);
    crc_bad  = crc_rx != 16'h0000;
    exc_func = hdr[1] != mbfc04_pkg::FC_READ_INPUT;
    exc_data = (frame_length != len_t'(8)) || (qty != 16'd1);
    exc_addr = {1'b0, offset} >= 17'(mbfc04_pkg::TABLE_ENTRIES);
    if (exc_func) begin
      exc_code = mbfc04_pkg::EXC_ILLEGAL_FUNC;
    end else if (exc_data) begin
      exc_code = mbfc04_pkg::EXC_ILLEGAL_DATA;
    end else begin
      exc_code = mbfc04_pkg::EXC_ILLEGAL_ADDR;
    end
    start_rsp = accept && (func == mbfc04_pkg::FUNC_GAP) && frame_ok && !crc_bad;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= 8'd1;
      register_base    <= 16'd0;
      stuck_timeout_ms <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbfc04_pkg::CFG_SLAVE_ADDR: slave_address    <= cfg_data[7:0];
        mbfc04_pkg::CFG_REG_BASE:   register_base    <= cfg_data;
        mbfc04_pkg::CFG_STUCK_MS:   stuck_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // receive side
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length    <= '0;
      idle_ms         <= '0;
      crc_fail_total  <= '0;
      exception_total <= '0;
      stuck_total     <= '0;
    end else if (accept) begin
      unique case (func)
        mbfc04_pkg::FUNC_BYTE: begin
          if (frame_length < RX_MAX) begin
            frame_length <= frame_length + 1'b1;
          end else begin
            frame_length <= '0;
          end
          idle_ms <= '0;
        end
        mbfc04_pkg::FUNC_GAP: begin
          if (frame_ok && crc_bad) begin
            crc_fail_total <= crc_fail_total + 16'd1;
          end
          if (start_rsp && (exc_func || exc_data || exc_addr)) begin
            exception_total <= exception_total + 16'd1;
          end
          frame_length <= '0;
        end
        mbfc04_pkg::FUNC_TICK: begin
          idle_ms <= idle_ms_next;
          if ((frame_length != '0) && (idle_ms_next > stuck_timeout_ms)) begin
            stuck_total  <= stuck_total + 16'd1;
            frame_length <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == mbfc04_pkg::FUNC_BYTE) && (frame_length < RX_MAX)) begin
      crc_rx <= crc_rx_next;
      for (int i = 0; i < 6; i++) begin
        if (frame_length == len_t'(i)) begin
          hdr[i] <= data_byte;
        end
      end
    end
  end

  // input register table
  always_ff @(posedge clk) begin
    if (accept && (func == mbfc04_pkg::FUNC_WRITE) &&
        ({1'b0, reg_index} < 5'(mbfc04_pkg::TABLE_ENTRIES))) begin
      tbl_mem[reg_index[mbfc04_pkg::TBL_AW-1:0]] <= reg_value;
    end
    if (start_rsp) begin
      rd_data <= tbl_mem[offset[mbfc04_pkg::TBL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (accept && (func == mbfc04_pkg::FUNC_WRITE) &&
          ({1'b0, reg_index} < 5'(mbfc04_pkg::TABLE_ENTRIES))) begin
        tbl_valid[reg_index[mbfc04_pkg::TBL_AW-1:0]] <= 1'b1;
      end
      if (start_rsp) begin
        rd_valid <= tbl_valid[offset[mbfc04_pkg::TBL_AW-1:0]];
      end
    end
  end

  // response sequencer
  assign body_n   = tx_exc ? 3'd3 : 3'd5;
  assign last_idx = body_n + 3'd1;
  assign tbl_val  = rd_valid ? rd_data : 16'h0000;
  assign load     = busy && (!m_tvalid || m_tready);

  always_comb begin
    if (tx_idx == body_n) begin
      cur_byte = crc_tx[7:0];
    end else if (tx_idx == last_idx) begin
      cur_byte = crc_tx[15:8];
    end else begin
      case (tx_idx)
        3'd0:    cur_byte = slave_address;
        3'd1:    cur_byte = tx_b1;
        3'd2:    cur_byte = tx_b2;
        3'd3:    cur_byte = tbl_val[15:8];
        default: cur_byte = tbl_val[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      tx_idx <= '0;
    end else if (start_rsp) begin
      busy   <= 1'b1;
      tx_idx <= '0;
    end else if (load) begin
      tx_idx <= tx_idx + 3'd1;
      if (tx_idx == last_idx) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_rsp) begin
      tx_exc     <= exc_func || exc_data || exc_addr;
      tx_b1      <= (exc_func || exc_data || exc_addr) ? (hdr[1] | mbfc04_pkg::EXC_FLAG)
                                                       : mbfc04_pkg::FC_READ_INPUT;
      tx_b2      <= (exc_func || exc_data || exc_addr) ? exc_code : mbfc04_pkg::REPLY_COUNT;
      crc_tx     <= mbfc04_pkg::CRC_INIT;
      snap_crc   <= crc_fail_total;
      snap_exc   <= (exc_func || exc_data || exc_addr) ? exception_total + 16'd1
                                                       : exception_total;
      snap_stuck <= stuck_total;
    end else if (load && (tx_idx < body_n)) begin
      crc_tx <= mbfc04_pkg::crc16_byte(crc_tx, cur_byte);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {snap_stuck, snap_exc, snap_crc, cur_byte};
      m_tlast <= tx_idx == last_idx;
    end
  end

endmodule
`default_nettype wire
